### src/delta_list_timer_queue_core_macros.svh
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_CORE_MACROS_SVH
`define DELTA_LIST_TIMER_QUEUE_CORE_MACROS_SVH

// assert on clk_i, disabled while rst_ni is low
`define DLTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form of the above
`define DLTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  `DLTQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### src/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Types, codes and defaults of the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int DEF_SLOTS       = 16;
  localparam int DEF_DELTA_WIDTH = 32;
  localparam int DEF_QUEUES      = 2;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_ADJ_FWD = 3'd3;
  localparam logic [2:0] OP_ADJ_BWD = 3'd4;

  localparam logic [1:0] SS_INACTIVE = 2'd0;
  localparam logic [1:0] SS_ACTIVE   = 2'd1;
  localparam logic [1:0] SS_REINSERT = 2'd2;

  localparam logic [1:0] EV_FIRED   = 2'd0;
  localparam logic [1:0] EV_REARMED = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_ZERO   = 2'd1;
  localparam logic [1:0] STS_QUEUED = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ENQ_START,
    ST_ENQ_RD,
    ST_ENQ_CMP,
    ST_ENQ_LINK,
    ST_ENQ_LINK2,
    ST_DEQ_START,
    ST_DEQ_RD,
    ST_DEQ_CMP,
    ST_DEQ_NXRD,
    ST_DEQ_NXADD,
    ST_DEQ_UNLINK,
    ST_EXP_RD,
    ST_EXP_CMP,
    ST_EMIT_EV,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_FWD_RD,
    ST_FWD_CMP,
    ST_BWD_RD,
    ST_BWD_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    state_e step;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       chain_ok;
    logic       id_ok;
    logic       units_zero;
    logic       id_busy;
    logic       len_zero;
    logic       d_zero;
    logic       d_lt;
    logic       d_eq;
    logic       u_lt;
    logic       walk_end;
    logic       hit;
    logic       delta_zero;
    logic [1:0] exp_prev;
    logic       pred_valid;
    logic       out_free;
  } stat_t;

endpackage

### src/dltq_if.sv
// ----------------------------------------------------------------------------
// dltq_if
// Request and result channels of the delta list timer queue.
// ----------------------------------------------------------------------------
interface dltq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        chain;
  logic [3:0]  timer_id;
  logic [31:0] interval;
  logic        activate_now;

  modport source (output valid, op, chain, timer_id, interval, activate_now, input ready);
  modport sink (input valid, op, chain, timer_id, interval, activate_now, output ready);
endinterface

interface dltq_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [3:0] slot_id;
  logic [1:0] prior_state;
  logic [1:0] status;
  logic       last;

  modport source (output valid, event_res, slot_id, prior_state, status, last,
                  input ready);
  modport sink (input valid, event_res, slot_id, prior_state, status, last,
                output ready);
endinterface

### src/dltq_ram.sv
// ----------------------------------------------------------------------------
// dltq_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Operation sequencer: walks insert, remove, tick, expiry and adjust steps.
// ----------------------------------------------------------------------------
module dltq_ctrl
  import dltq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  req_ready_o
);

  state_e state_q, state_d;
  state_e exp_end;
  state_e enq_end;

  always_comb begin
    exp_end = (stat_i.op == OP_ADJ_FWD) ? ST_FWD_RD : ST_DONE;
    enq_end = (stat_i.op == OP_INSERT) ? ST_DONE : ST_EMIT_EV;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = ST_DONE;
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.chain_ok && stat_i.id_ok && !stat_i.units_zero && !stat_i.id_busy)
              state_d = ST_ENQ_START;
          end
          OP_REMOVE: begin
            if (stat_i.id_ok && stat_i.id_busy) state_d = ST_DEQ_START;
          end
          OP_TICK: begin
            if (stat_i.chain_ok && !stat_i.len_zero) state_d = ST_TICK_RD;
          end
          OP_ADJ_FWD: begin
            if (stat_i.chain_ok) state_d = ST_FWD_RD;
          end
          OP_ADJ_BWD: begin
            if (stat_i.chain_ok && !stat_i.len_zero) state_d = ST_BWD_RD;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_ENQ_START: begin
        state_d = (stat_i.len_zero || stat_i.d_zero) ? ST_ENQ_LINK : ST_ENQ_RD;
      end
      ST_ENQ_RD: state_d = ST_ENQ_CMP;
      ST_ENQ_CMP: begin
        if (stat_i.d_lt || stat_i.d_eq || stat_i.walk_end) state_d = ST_ENQ_LINK;
        else state_d = ST_ENQ_RD;
      end
      ST_ENQ_LINK: state_d = stat_i.pred_valid ? ST_ENQ_LINK2 : enq_end;
      ST_ENQ_LINK2: state_d = enq_end;
      ST_DEQ_START: state_d = ST_DEQ_RD;
      ST_DEQ_RD: state_d = ST_DEQ_CMP;
      ST_DEQ_CMP: begin
        if (!stat_i.hit) state_d = ST_DEQ_RD;
        else if (stat_i.walk_end) state_d = ST_DEQ_UNLINK;
        else state_d = ST_DEQ_NXRD;
      end
      ST_DEQ_NXRD: state_d = ST_DEQ_NXADD;
      ST_DEQ_NXADD: state_d = ST_DEQ_UNLINK;
      ST_DEQ_UNLINK: state_d = ST_DONE;
      ST_EXP_RD: state_d = stat_i.len_zero ? exp_end : ST_EXP_CMP;
      ST_EXP_CMP: begin
        if (!stat_i.delta_zero) state_d = exp_end;
        else if (stat_i.exp_prev == SS_ACTIVE) state_d = ST_EMIT_EV;
        else if (stat_i.exp_prev == SS_REINSERT) state_d = ST_ENQ_START;
        else state_d = ST_EXP_RD;
      end
      ST_EMIT_EV: begin
        if (stat_i.out_free) state_d = ST_EXP_RD;
      end
      ST_TICK_RD: state_d = ST_TICK_CMP;
      ST_TICK_CMP: state_d = ST_EXP_RD;
      ST_FWD_RD: begin
        state_d = (stat_i.units_zero || stat_i.len_zero) ? ST_DONE : ST_FWD_CMP;
      end
      ST_FWD_CMP: state_d = stat_i.u_lt ? ST_DONE : ST_EXP_RD;
      ST_BWD_RD: state_d = ST_BWD_CMP;
      ST_BWD_CMP: state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o  = (state_q == ST_IDLE);
    cmd_o.step   = state_q;
    cmd_o.accept = (state_q == ST_IDLE) && req_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/dltq_dp.sv
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath: slot tables, linked delta queues, walk registers and result
// register.
// ----------------------------------------------------------------------------
module dltq_dp
  import dltq_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int DELTA_WIDTH = DEF_DELTA_WIDTH,
  parameter int QUEUES      = DEF_QUEUES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [2:0]  op_i,
  input  logic        chain_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] interval_i,
  input  logic        activate_now_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output logic [1:0]  event_res_o,
  output logic [3:0]  slot_id_o,
  output logic [1:0]  prior_state_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int DW = DELTA_WIDTH;

  // request
  logic [2:0]    op_q;
  logic          chain_q;
  logic [3:0]    id_raw_q;
  logic [DW-1:0] units_q, units_d;
  logic          now_q;
  logic [QW-1:0] q_q, q_d;

  // walk
  logic [SW-1:0] s_q, s_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [SW-1:0] pred_q, pred_d;
  logic          pred_valid_q, pred_valid_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [DW-1:0] d_q, d_d;
  logic [1:0]    ev_q, ev_d;
  logic [1:0]    prev_res_q, prev_res_d;
  logic [1:0]    sts_res_q, sts_res_d;

  // slot and queue tables
  logic [1:0]    st_q   [SLOTS];
  logic [QW-1:0] sq_q   [SLOTS];
  logic [SW-1:0] head_q [QUEUES];
  logic [LW-1:0] len_q  [QUEUES];

  // result register
  logic          out_valid_q;
  logic [1:0]    out_ev_q;
  logic [3:0]    out_slot_q;
  logic [1:0]    out_prev_q;
  logic [1:0]    out_sts_q;
  logic          out_last_q;

  // rams
  logic [SW-1:0] rd_addr;
  logic [DW-1:0] delta_rd, init_rd;
  logic [SW-1:0] next_rd;
  logic          dw_en, nw_en, iw_en;
  logic [SW-1:0] dw_addr, nw_addr;
  logic [DW-1:0] dw_data;
  logic [SW-1:0] nw_data;

  logic [SW-1:0] id_idx;
  logic [SW-1:0] head_cur;
  logic [LW-1:0] len_cur;
  logic          out_free;
  logic          out_load;
  logic [DW-1:0] units_in;

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DW] ? {DW{1'b1}} : s[DW-1:0];
  endfunction

  assign id_idx   = SW'(id_raw_q);
  assign head_cur = head_q[q_q];
  assign len_cur  = len_q[q_q];
  assign out_free = !out_valid_q || res_ready_i;
  assign units_in = DW'(interval_i);
  assign out_load = out_free && ((cmd_i.step == ST_EMIT_EV) || (cmd_i.step == ST_DONE));

  always_comb begin
    case (cmd_i.step)
      ST_TICK_RD, ST_FWD_RD, ST_BWD_RD, ST_EXP_RD: rd_addr = head_cur;
      default: rd_addr = cur_q;
    endcase
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.chain_ok   = (32'(chain_q) < 32'(QUEUES));
    stat_o.id_ok      = (32'(id_raw_q) < 32'(SLOTS));
    stat_o.units_zero = (units_q == '0);
    stat_o.id_busy    = (st_q[id_idx] != SS_INACTIVE);
    stat_o.len_zero   = (len_cur == '0);
    stat_o.d_zero     = (d_q == '0);
    stat_o.d_lt       = (d_q < delta_rd);
    stat_o.d_eq       = (d_q == delta_rd);
    stat_o.u_lt       = (units_q < delta_rd);
    stat_o.walk_end   = ((pos_q + LW'(1)) == len_cur);
    stat_o.hit        = (cur_q == s_q);
    stat_o.delta_zero = (delta_rd == '0);
    stat_o.exp_prev   = st_q[head_cur];
    stat_o.pred_valid = pred_valid_q;
    stat_o.out_free   = out_free;
  end

  // ram write ports
  always_comb begin
    dw_en   = 1'b0;
    dw_addr = cur_q;
    dw_data = d_q;
    nw_en   = 1'b0;
    nw_addr = s_q;
    nw_data = cur_q;
    iw_en   = 1'b0;
    case (cmd_i.step)
      ST_DECODE: begin
        iw_en = (op_q == OP_INSERT) && stat_o.chain_ok && stat_o.id_ok
                && !stat_o.units_zero && !stat_o.id_busy;
      end
      ST_ENQ_CMP: begin
        dw_en   = stat_o.d_lt;
        dw_data = delta_rd - d_q;
      end
      ST_ENQ_LINK: begin
        dw_en   = 1'b1;
        dw_addr = s_q;
        nw_en   = 1'b1;
      end
      ST_ENQ_LINK2: begin
        nw_en   = 1'b1;
        nw_addr = pred_q;
        nw_data = s_q;
      end
      ST_DEQ_NXADD: begin
        dw_en   = 1'b1;
        dw_data = sat_add(delta_rd, d_q);
      end
      ST_DEQ_UNLINK: begin
        nw_en   = pred_valid_q;
        nw_addr = pred_q;
      end
      ST_TICK_CMP: begin
        dw_en   = !stat_o.delta_zero;
        dw_addr = head_cur;
        dw_data = delta_rd - DW'(1);
      end
      ST_FWD_CMP: begin
        dw_en   = 1'b1;
        dw_addr = head_cur;
        dw_data = stat_o.u_lt ? (delta_rd - units_q) : '0;
      end
      ST_BWD_CMP: begin
        dw_en   = 1'b1;
        dw_addr = head_cur;
        dw_data = sat_add(delta_rd, units_q);
      end
      default: dw_en = 1'b0;
    endcase
  end

  // walk register next values
  always_comb begin
    q_d          = q_q;
    units_d      = units_q;
    s_d          = s_q;
    cur_d        = cur_q;
    pred_d       = pred_q;
    pred_valid_d = pred_valid_q;
    pos_d        = pos_q;
    d_d          = d_q;
    ev_d         = ev_q;
    prev_res_d   = prev_res_q;
    sts_res_d    = sts_res_q;
    case (cmd_i.step)
      ST_IDLE: begin
        q_d     = QW'(chain_i);
        units_d = units_in;
      end
      ST_DECODE: begin
        s_d        = id_idx;
        d_d        = units_q;
        prev_res_d = SS_INACTIVE;
        sts_res_d  = STS_OK;
        if ((op_q == OP_REMOVE) && stat_o.id_ok) prev_res_d = st_q[id_idx];
        if ((op_q == OP_INSERT) && stat_o.chain_ok && stat_o.id_ok) begin
          if (stat_o.units_zero) sts_res_d = STS_ZERO;
          else if (stat_o.id_busy) sts_res_d = STS_QUEUED;
        end
      end
      ST_ENQ_START: begin
        cur_d        = head_cur;
        pos_d        = '0;
        pred_valid_d = 1'b0;
      end
      ST_ENQ_CMP: begin
        if (!stat_o.d_lt) begin
          d_d          = d_q - delta_rd;
          pred_d       = cur_q;
          pred_valid_d = 1'b1;
          cur_d        = next_rd;
          pos_d        = pos_q + LW'(1);
        end
      end
      ST_DEQ_START: begin
        q_d          = sq_q[s_q];
        cur_d        = head_q[sq_q[s_q]];
        pos_d        = '0;
        pred_valid_d = 1'b0;
      end
      ST_DEQ_CMP: begin
        cur_d = next_rd;
        if (stat_o.hit) begin
          d_d = delta_rd;
        end else begin
          pred_d       = cur_q;
          pred_valid_d = 1'b1;
          pos_d        = pos_q + LW'(1);
        end
      end
      ST_EXP_CMP: begin
        s_d  = head_cur;
        d_d  = init_rd;
        ev_d = (stat_o.exp_prev == SS_ACTIVE) ? EV_FIRED : EV_REARMED;
      end
      ST_FWD_CMP: begin
        if (!stat_o.u_lt) units_d = units_q - delta_rd;
      end
      default: q_d = q_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_i;
      chain_q  <= chain_i;
      id_raw_q <= timer_id_i;
      now_q    <= activate_now_i;
    end
    q_q        <= q_d;
    units_q    <= units_d;
    s_q        <= s_d;
    cur_q      <= cur_d;
    pred_q     <= pred_d;
    pos_q      <= pos_d;
    d_q        <= d_d;
    ev_q       <= ev_d;
    prev_res_q <= prev_res_d;
    sts_res_q  <= sts_res_d;
    if (cmd_i.step == ST_ENQ_LINK) sq_q[s_q] <= q_q;
    if (out_load) begin
      if (cmd_i.step == ST_DONE) begin
        out_ev_q   <= EV_DONE;
        out_slot_q <= ((op_q == OP_INSERT) || (op_q == OP_REMOVE)) ? id_raw_q : 4'd0;
        out_prev_q <= prev_res_q;
        out_sts_q  <= sts_res_q;
        out_last_q <= 1'b1;
      end else begin
        out_ev_q   <= ev_q;
        out_slot_q <= 4'(s_q);
        out_prev_q <= SS_INACTIVE;
        out_sts_q  <= STS_OK;
        out_last_q <= 1'b0;
      end
    end
  end

  // control state: slot states, queue heads and lengths, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) st_q[i] <= SS_INACTIVE;
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      pred_valid_q <= pred_valid_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.step)
        ST_DECODE: begin
          if (iw_en) st_q[id_idx] <= now_q ? SS_ACTIVE : SS_REINSERT;
        end
        ST_ENQ_LINK: begin
          if (!pred_valid_q) head_q[q_q] <= s_q;
          len_q[q_q] <= len_cur + LW'(1);
        end
        ST_DEQ_UNLINK: begin
          if (!pred_valid_q) head_q[q_q] <= cur_q;
          len_q[q_q] <= len_cur - LW'(1);
          st_q[s_q]  <= SS_INACTIVE;
        end
        ST_EXP_CMP: begin
          if (stat_o.delta_zero) begin
            head_q[q_q] <= next_rd;
            len_q[q_q]  <= len_cur - LW'(1);
            st_q[head_cur] <= (stat_o.exp_prev == SS_REINSERT) ? SS_ACTIVE : SS_INACTIVE;
          end
        end
        default: ;
      endcase
    end
  end

  dltq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_delta_ram (
    .clk_i   (clk_i),
    .we_i    (dw_en),
    .waddr_i (dw_addr),
    .wdata_i (dw_data),
    .raddr_i (rd_addr),
    .rdata_o (delta_rd)
  );

  dltq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nw_en),
    .waddr_i (nw_addr),
    .wdata_i (nw_data),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  dltq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_init_ram (
    .clk_i   (clk_i),
    .we_i    (iw_en),
    .waddr_i (id_idx),
    .wdata_i (units_q),
    .raddr_i (rd_addr),
    .rdata_o (init_rd)
  );

  assign res_valid_o   = out_valid_q;
  assign event_res_o   = out_ev_q;
  assign slot_id_o     = out_slot_q;
  assign prior_state_o = out_prev_q;
  assign status_o      = out_sts_q;
  assign last_o        = out_last_q;

endmodule

### src/delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Timer slots on delta-ordered linked queues; insert, remove, tick and
// adjust operations, with fired, rearmed and done results.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | accept
//  req_i   | in  | op, chain, timer_id, interval, activate_now     | valid & ready
//  res_o   | out | event_res, slot_id, prior_state, status, last   | valid & ready
//
//  One operation at a time; req_i.ready is high only between operations.
//  Insert walks the queued slots, then links behind a slot if one precedes.
//  Remove walks to its position and adds its delta to a following slot.
//  Tick decrements the head, emits an event per fired slot, reinserts per rearm;
//  backward adjust adds to the head; forward adjust consumes heads it reaches.
//  Reset clears slot states, queue lengths and the FSM at once; no sweep.
//  A stalled res_o holds the FSM in its emit or done step; nothing is dropped.
module delta_list_timer_queue_core
  import dltq_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int DELTA_WIDTH = DEF_DELTA_WIDTH,
  parameter int QUEUES      = DEF_QUEUES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dltq_req_if.sink      req_i,
  dltq_res_if.source    res_o
);

  cmd_t  cmd;
  stat_t stat;

  dltq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .req_ready_o (req_i.ready)
  );

  dltq_dp #(
    .SLOTS       (SLOTS),
    .DELTA_WIDTH (DELTA_WIDTH),
    .QUEUES      (QUEUES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (req_i.op),
    .chain_i        (req_i.chain),
    .timer_id_i     (req_i.timer_id),
    .interval_i     (req_i.interval),
    .activate_now_i (req_i.activate_now),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .event_res_o    (res_o.event_res),
    .slot_id_o      (res_o.slot_id),
    .prior_state_o  (res_o.prior_state),
    .status_o       (res_o.status),
    .last_o         (res_o.last)
  );

endmodule

### src/dltq_checker.sv
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level checks of the result channel.
// ----------------------------------------------------------------------------
`include "delta_list_timer_queue_core_macros.svh"

module dltq_checker
  import dltq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] event_res_i,
  input logic [3:0] slot_id_i,
  input logic [1:0] prior_state_i,
  input logic [1:0] status_i,
  input logic       last_i
);

  `DLTQ_ASSERT(a_valid_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped")
  `DLTQ_ASSERT(a_data_hold, res_valid_i && !res_ready_i |=> $stable(slot_id_i) && $stable(event_res_i), "stalled result changed")
  `DLTQ_ASSERT_IMP(a_last_done, res_valid_i, last_i == (event_res_i == EV_DONE), "last not on done")
  `DLTQ_ASSERT_IMP(a_event_clean, res_valid_i && !last_i, prior_state_i == SS_INACTIVE && status_i == STS_OK, "event carries status")

endmodule

bind delta_list_timer_queue_core dltq_checker u_dltq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .event_res_i   (res_o.event_res),
  .slot_id_i     (res_o.slot_id),
  .prior_state_i (res_o.prior_state),
  .status_i      (res_o.status),
  .last_i        (res_o.last)
);
